/* rtl/core/robb_pkg.sv */
`default_nettype none
package robb_pkg;

  // configuration port
  localparam int CFG_IDX_W = 3;
  localparam int TOL_BITS  = 10;
  localparam int FACE_W    = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER = 3'd0,
    REG_AXIS_X = 3'd1,
    REG_AXIS_Y = 3'd2,
    REG_AXIS_Z = 3'd3,
    REG_HALF   = 3'd4,
    REG_TOL    = 3'd5
  } reg_idx_t;

  typedef enum logic [FACE_W-1:0] {
    FACE_NONE  = 3'd0,
    FACE_POS_X = 3'd1,
    FACE_NEG_X = 3'd2,
    FACE_POS_Y = 3'd3,
    FACE_NEG_Y = 3'd4,
    FACE_POS_Z = 3'd5,
    FACE_NEG_Z = 3'd6
  } face_t;

  // pipeline control shared by the stage groups
  typedef struct packed {
    logic adv;
    logic in_valid;
  } pipe_ctl_t;

endpackage
`default_nettype wire

/* rtl/core/robb_cfg.sv */
`default_nettype none
module robb_cfg #(
  parameter int COORD_BITS = 20,
  parameter int FRAC_BITS  = 10,
  parameter int AXIS_BITS  = 16,
  parameter int CFG_W      = 60
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [robb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_W-1:0]                    cfg_data,
  output logic [3*COORD_BITS-1:0]                  center,
  output logic [3*AXIS_BITS-1:0]                   axis_x,
  output logic [3*AXIS_BITS-1:0]                   axis_y,
  output logic [3*AXIS_BITS-1:0]                   axis_z,
  output logic [3*COORD_BITS-1:0]                  half,
  output logic [robb_pkg::TOL_BITS-1:0]            tol
);
  import robb_pkg::*;

  localparam int AF = AXIS_BITS - 2;

  // identity axes, half extent of one half
  localparam logic [AXIS_BITS-1:0]  AXIS_ONE = AXIS_BITS'(1) << AF;
  localparam logic [COORD_BITS-1:0] HALF_RST = COORD_BITS'(1) << (FRAC_BITS - 1);

  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      center <= '0;
      axis_x <= {{(2*AXIS_BITS){1'b0}}, AXIS_ONE};
      axis_y <= {{AXIS_BITS{1'b0}}, AXIS_ONE, {AXIS_BITS{1'b0}}};
      axis_z <= {AXIS_ONE, {(2*AXIS_BITS){1'b0}}};
      half   <= {HALF_RST, HALF_RST, HALF_RST};
      tol    <= TOL_BITS'(1);
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CENTER: center <= cfg_data[3*COORD_BITS-1:0];
        REG_AXIS_X: axis_x <= cfg_data[3*AXIS_BITS-1:0];
        REG_AXIS_Y: axis_y <= cfg_data[3*AXIS_BITS-1:0];
        REG_AXIS_Z: axis_z <= cfg_data[3*AXIS_BITS-1:0];
        REG_HALF:   half   <= cfg_data[3*COORD_BITS-1:0];
        REG_TOL:    tol    <= cfg_data[TOL_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/core/robb_proj.sv */
`default_nettype none
module robb_proj #(
  parameter int COORD_BITS = 20,
  parameter int FRAC_BITS  = 10,
  parameter int AXIS_BITS  = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire robb_pkg::pipe_ctl_t                ctl,
  input  wire logic signed [COORD_BITS-1:0]       org_in [3],
  input  wire logic signed [COORD_BITS-1:0]       dir_in [3],
  input  wire logic [COORD_BITS+1:0]              maxd_in,
  input  wire logic [3*COORD_BITS-1:0]            center,
  input  wire logic [3*AXIS_BITS-1:0]             axis_x,
  input  wire logic [3*AXIS_BITS-1:0]             axis_y,
  input  wire logic [3*AXIS_BITS-1:0]             axis_z,
  input  wire logic [3*COORD_BITS-1:0]            half,
  output logic                                    out_valid,
  output logic signed [COORD_BITS-1:0]            org_out [3],
  output logic signed [COORD_BITS-1:0]            dir_out [3],
  output logic [COORD_BITS+1:0]                   maxd_out,
  output logic signed [COORD_BITS+AXIS_BITS+2:0]  pp_out [3],
  output logic signed [COORD_BITS+AXIS_BITS+1:0]  dp_out [3],
  output logic signed [COORD_BITS+AXIS_BITS+FRAC_BITS+3:0] num_neg [3],
  output logic signed [COORD_BITS+AXIS_BITS+FRAC_BITS+3:0] num_pos [3],
  output logic [2:0]                              par,
  output logic                                    pmiss
);
  import robb_pkg::*;

  localparam int CW     = COORD_BITS;
  localparam int AB     = AXIS_BITS;
  localparam int AF     = AXIS_BITS - 2;
  localparam int DW     = CW + 2;
  localparam int OFF_W  = CW + 1;
  localparam int PR_W   = OFF_W + AB;
  localparam int DR_W   = CW + AB;
  localparam int PP_W   = CW + AB + 3;
  localparam int DP_W   = CW + AB + 2;
  localparam int DIFF_W = PP_W + 1;
  localparam int NUM_W  = DIFF_W + FRAC_BITS;

  logic signed [AB-1:0] ax [3][3];
  logic                 v1, v2, v3;

  logic signed [OFF_W-1:0] s1_off [3];
  logic signed [CW-1:0]    s1_org [3], s1_dir [3], s2_org [3], s2_dir [3];
  logic signed [CW-1:0]    s3_org [3], s3_dir [3];
  logic [DW-1:0]           s1_maxd, s2_maxd, s3_maxd;
  logic signed [PR_W-1:0]  s2_pprod [3][3];
  logic signed [DR_W-1:0]  s2_dprod [3][3];
  logic signed [PP_W-1:0]  s3_pp [3];
  logic signed [DP_W-1:0]  s3_dp [3];

  // axis fields as a matrix, row per box axis
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ax[0][k] = signed'(axis_x[k*AB +: AB]);
      ax[1][k] = signed'(axis_y[k*AB +: AB]);
      ax[2][k] = signed'(axis_z[k*AB +: AB]);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (ctl.adv) begin
      v1        <= ctl.in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  // stage 1: offset from box center
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      for (int k = 0; k < 3; k++) begin
        s1_off[k] <= OFF_W'(org_in[k]) - OFF_W'(signed'(center[k*CW +: CW]));
        s1_org[k] <= org_in[k];
        s1_dir[k] <= dir_in[k];
      end
      s1_maxd <= maxd_in;
    end
  end

  // stage 2: products against each axis
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      for (int a = 0; a < 3; a++) begin
        for (int k = 0; k < 3; k++) begin
          s2_pprod[a][k] <= PR_W'(s1_off[k]) * PR_W'(ax[a][k]);
          s2_dprod[a][k] <= DR_W'(s1_dir[k]) * DR_W'(ax[a][k]);
        end
      end
      s2_org  <= s1_org;
      s2_dir  <= s1_dir;
      s2_maxd <= s1_maxd;
    end
  end

  // stage 3: dot products
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      for (int a = 0; a < 3; a++) begin
        s3_pp[a] <= PP_W'(s2_pprod[a][0]) + PP_W'(s2_pprod[a][1]) + PP_W'(s2_pprod[a][2]);
        s3_dp[a] <= DP_W'(s2_dprod[a][0]) + DP_W'(s2_dprod[a][1]) + DP_W'(s2_dprod[a][2]);
      end
      s3_org  <= s2_org;
      s3_dir  <= s2_dir;
      s3_maxd <= s2_maxd;
    end
  end

  // stage 4: slab numerators and parallel axis check
  logic signed [DIFF_W-1:0] hs [3];
  logic signed [DIFF_W-1:0] ps [3];
  logic [2:0]               par_c, out_c;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      hs[a]    = DIFF_W'(signed'({1'b0, half[a*CW +: CW], {AF{1'b0}}}));
      ps[a]    = DIFF_W'(s3_pp[a]);
      par_c[a] = (s3_dp[a] == '0);
      out_c[a] = (ps[a] < -hs[a]) || (ps[a] > hs[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      for (int a = 0; a < 3; a++) begin
        num_neg[a] <= NUM_W'({-hs[a] - ps[a], {FRAC_BITS{1'b0}}});
        num_pos[a] <= NUM_W'({hs[a] - ps[a], {FRAC_BITS{1'b0}}});
      end
      par      <= par_c;
      pmiss    <= |(par_c & out_c);
      pp_out   <= s3_pp;
      dp_out   <= s3_dp;
      org_out  <= s3_org;
      dir_out  <= s3_dir;
      maxd_out <= s3_maxd;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/robb_div.sv */
`default_nettype none
module robb_div #(
  parameter int NUM_W = 50,
  parameter int DEN_W = 38
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic signed [NUM_W-1:0]  num,
  input  wire logic signed [DEN_W-1:0]  den,
  output logic signed [NUM_W:0]         quo
);

  // numerator bits leave the top of nq while quotient bits enter the bottom
  logic [NUM_W-1:0] nq   [NUM_W+1];
  logic [DEN_W-1:0] rem  [NUM_W+1];
  logic [DEN_W-1:0] dm   [NUM_W+1];
  logic             neg  [NUM_W+1];

  // magnitudes and result sign
  always_ff @(posedge clk) begin
    if (en) begin
      nq[0]  <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      dm[0]  <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
      rem[0] <= '0;
      neg[0] <= num[NUM_W-1] ^ den[DEN_W-1];
    end
  end

  // one restoring step per stage
  for (genvar j = 0; j < NUM_W; j++) begin : g_step
    logic [DEN_W:0] trial;
    logic           ge;
    assign trial = {rem[j], nq[j][NUM_W-1]};
    assign ge    = trial >= {1'b0, dm[j]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1] <= ge ? DEN_W'(trial - {1'b0, dm[j]}) : trial[DEN_W-1:0];
        nq[j+1]  <= {nq[j][NUM_W-2:0], ge};
        dm[j+1]  <= dm[j];
        neg[j+1] <= neg[j];
      end
    end
  end

  // sign of a quotient truncated toward zero
  always_ff @(posedge clk) begin
    if (en) begin
      quo <= neg[NUM_W] ? -signed'({1'b0, nq[NUM_W]}) : signed'({1'b0, nq[NUM_W]});
    end
  end

endmodule
`default_nettype wire

/* rtl/core/robb_hit.sv */
`default_nettype none
module robb_hit #(
  parameter int COORD_BITS = 20,
  parameter int FRAC_BITS  = 10,
  parameter int AXIS_BITS  = 16
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst,
  input  wire robb_pkg::pipe_ctl_t                          ctl,
  input  wire logic signed [COORD_BITS-1:0]                 org [3],
  input  wire logic signed [COORD_BITS-1:0]                 dir [3],
  input  wire logic [COORD_BITS+1:0]                        maxd,
  input  wire logic signed [COORD_BITS+AXIS_BITS+2:0]       pp [3],
  input  wire logic signed [COORD_BITS+AXIS_BITS+1:0]       dp [3],
  input  wire logic [2:0]                                   par,
  input  wire logic                                         pmiss,
  input  wire logic signed [COORD_BITS+AXIS_BITS+FRAC_BITS+4:0] t_neg [3],
  input  wire logic signed [COORD_BITS+AXIS_BITS+FRAC_BITS+4:0] t_pos [3],
  input  wire logic [3*COORD_BITS-1:0]                      half,
  input  wire logic [robb_pkg::TOL_BITS-1:0]                tol,
  output logic                                              out_valid,
  output logic                                              hit,
  output logic [COORD_BITS+1:0]                             distance,
  output logic signed [COORD_BITS-1:0]                      point [3],
  output robb_pkg::face_t                                   face
);
  import robb_pkg::*;

  localparam int CW    = COORD_BITS;
  localparam int AF    = AXIS_BITS - 2;
  localparam int DW    = CW + 2;
  localparam int PP_W  = CW + AXIS_BITS + 3;
  localparam int DP_W  = CW + AXIS_BITS + 2;
  localparam int TW    = CW + AXIS_BITS + FRAC_BITS + 5;
  localparam int MP_W  = CW + DW + 1;
  localparam int MQ_W  = DP_W + DW + 1;
  localparam int PS_W  = MP_W + 1;
  localparam int QW    = MQ_W + 1;
  localparam int DD_W  = QW + 1;

  localparam logic signed [PS_W-1:0] PMAX = PS_W'(signed'({1'b0, {(CW-1){1'b1}}}));
  localparam logic signed [PS_W-1:0] PMIN = PS_W'(signed'({1'b1, {(CW-1){1'b0}}}));

  logic v1, v2, v3, v4;

  // stage 1: order each slab's entry and exit
  logic signed [TW-1:0]   h1_lo [3], h1_hi [3];
  logic [2:0]             h1_par;
  logic                   h1_pmiss;
  logic signed [CW-1:0]   h1_org [3], h1_dir [3];
  logic [DW-1:0]          h1_maxd;
  logic signed [PP_W-1:0] h1_pp [3];
  logic signed [DP_W-1:0] h1_dp [3];

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      for (int a = 0; a < 3; a++) begin
        h1_lo[a] <= (t_neg[a] > t_pos[a]) ? t_pos[a] : t_neg[a];
        h1_hi[a] <= (t_neg[a] > t_pos[a]) ? t_neg[a] : t_pos[a];
      end
      h1_par   <= par;
      h1_pmiss <= pmiss;
      h1_org   <= org;
      h1_dir   <= dir;
      h1_maxd  <= maxd;
      h1_pp    <= pp;
      h1_dp    <= dp;
    end
  end

  // stage 2: intersect the slabs, decide the hit
  logic signed [TW-1:0]   lo_c, hi_c;
  logic                   bnd_c, hit_c;
  logic                   h2_hit;
  logic [DW-1:0]          h2_lo;
  logic signed [CW-1:0]   h2_org [3], h2_dir [3];
  logic signed [PP_W-1:0] h2_pp [3];
  logic signed [DP_W-1:0] h2_dp [3];

  always_comb begin
    lo_c  = '0;
    hi_c  = '0;
    bnd_c = 1'b0;
    for (int a = 0; a < 3; a++) begin
      if (!h1_par[a]) begin
        if (!bnd_c) begin
          lo_c = h1_lo[a];
          hi_c = h1_hi[a];
        end else begin
          if (h1_lo[a] > lo_c) lo_c = h1_lo[a];
          if (h1_hi[a] < hi_c) hi_c = h1_hi[a];
        end
        bnd_c = 1'b1;
      end
    end
    hit_c = !h1_pmiss && bnd_c && (lo_c <= hi_c) && !lo_c[TW-1] &&
            (lo_c <= TW'(signed'({1'b0, h1_maxd})));
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      h2_hit <= hit_c;
      h2_lo  <= lo_c[DW-1:0];
      h2_org <= h1_org;
      h2_dir <= h1_dir;
      h2_pp  <= h1_pp;
      h2_dp  <= h1_dp;
    end
  end

  // stage 3: scale direction and axis dot products by the entry parameter
  logic signed [MP_W-1:0] h3_mp [3];
  logic signed [MQ_W-1:0] h3_mq [3];
  logic                   h3_hit;
  logic [DW-1:0]          h3_lo;
  logic signed [CW-1:0]   h3_org [3];
  logic signed [PP_W-1:0] h3_pp [3];

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      for (int k = 0; k < 3; k++) begin
        h3_mp[k] <= MP_W'(h2_dir[k]) * MP_W'(signed'({1'b0, h2_lo}));
        h3_mq[k] <= MQ_W'(h2_dp[k]) * MQ_W'(signed'({1'b0, h2_lo}));
      end
      h3_hit <= h2_hit;
      h3_lo  <= h2_lo;
      h3_org <= h2_org;
      h3_pp  <= h2_pp;
    end
  end

  // stage 4: hit point with saturation, distance to each face plane
  logic signed [PS_W-1:0] ps_c [3];
  logic signed [QW-1:0]   q_c [3];
  logic signed [DD_W-1:0] hq_c [3], dpos_c [3], dneg_c [3];
  logic signed [CW-1:0]   h4_pt [3];
  logic [DD_W-1:0]        h4_apos [3], h4_aneg [3];
  logic                   h4_hit;
  logic [DW-1:0]          h4_lo;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ps_c[k]   = PS_W'(h3_org[k]) + PS_W'(h3_mp[k] >>> FRAC_BITS);
      q_c[k]    = QW'(h3_pp[k]) + QW'(h3_mq[k] >>> FRAC_BITS);
      hq_c[k]   = DD_W'(signed'({1'b0, half[k*CW +: CW], {AF{1'b0}}}));
      dpos_c[k] = DD_W'(q_c[k]) - hq_c[k];
      dneg_c[k] = DD_W'(q_c[k]) + hq_c[k];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      for (int k = 0; k < 3; k++) begin
        if (ps_c[k] > PMAX)      h4_pt[k] <= PMAX[CW-1:0];
        else if (ps_c[k] < PMIN) h4_pt[k] <= PMIN[CW-1:0];
        else                     h4_pt[k] <= ps_c[k][CW-1:0];
        h4_apos[k] <= dpos_c[k][DD_W-1] ? DD_W'(-dpos_c[k]) : DD_W'(dpos_c[k]);
        h4_aneg[k] <= dneg_c[k][DD_W-1] ? DD_W'(-dneg_c[k]) : DD_W'(dneg_c[k]);
      end
      h4_hit <= h3_hit;
      h4_lo  <= h3_lo;
    end
  end

  // stage 5: face priority and output register
  logic [DD_W-1:0] tol_s;
  logic [2:0]      on_pos, on_neg;
  face_t           face_c;

  always_comb begin
    tol_s = DD_W'({tol, {AF{1'b0}}});
    for (int k = 0; k < 3; k++) begin
      on_pos[k] = h4_apos[k] < tol_s;
      on_neg[k] = h4_aneg[k] < tol_s;
    end
    if (on_pos[0])      face_c = FACE_POS_X;
    else if (on_neg[0]) face_c = FACE_NEG_X;
    else if (on_pos[1]) face_c = FACE_POS_Y;
    else if (on_neg[1]) face_c = FACE_NEG_Y;
    else if (on_pos[2]) face_c = FACE_POS_Z;
    else if (on_neg[2]) face_c = FACE_NEG_Z;
    else                face_c = FACE_NONE;
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      hit      <= h4_hit;
      distance <= h4_hit ? h4_lo : '0;
      for (int k = 0; k < 3; k++) begin
        point[k] <= h4_hit ? h4_pt[k] : '0;
      end
      face     <= h4_hit ? face_c : FACE_NONE;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (ctl.adv) begin
      v1        <= ctl.in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/ray_obb_slab_intersect_unit.sv */
// pipeline: 4 projection stages + (COORD_BITS+AXIS_BITS+FRAC_BITS+6) divider stages
//   + 5 result stages
// throughput: one ray per cycle; the six slab dividers are fully pipelined,
//   one quotient bit per stage, and the whole pipe holds while the output stalls
// reset: synchronous, clears all valid bits; box registers return to the unit
//   box at the origin (identity axes, half extent one half, tolerance one lsb)
`default_nettype none
module ray_obb_slab_intersect_unit #(
  parameter int COORD_BITS = 20,
  parameter int FRAC_BITS  = 10,
  parameter int AXIS_BITS  = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, max_distance, zero pad
  input  wire logic [((6*COORD_BITS+COORD_BITS+2+7)/8)*8-1:0] s_axis_tdata,
  input  wire logic                                     s_axis_tvalid,
  output logic                                          s_axis_tready,
  // distance, point_x, point_y, point_z, face_code, zero pad
  output logic [((4*COORD_BITS+2+robb_pkg::FACE_W+7)/8)*8-1:0] m_axis_tdata,
  // hit
  output logic                                          m_axis_tuser,
  output logic                                          m_axis_tvalid,
  input  wire logic                                     m_axis_tready,
  input  wire logic                                     cfg_valid,
  output logic                                          cfg_ready,
  input  wire logic [robb_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  wire logic [((COORD_BITS > AXIS_BITS) ? 3*COORD_BITS : 3*AXIS_BITS)-1:0] cfg_data
);
  import robb_pkg::*;

  localparam int CW      = COORD_BITS;
  localparam int AB      = AXIS_BITS;
  localparam int DW      = CW + 2;
  localparam int CFG_W   = (CW > AB) ? 3*CW : 3*AB;
  localparam int PP_W    = CW + AB + 3;
  localparam int DP_W    = CW + AB + 2;
  localparam int NUM_W   = CW + AB + FRAC_BITS + 4;
  localparam int DIV_LAT = NUM_W + 2;
  localparam int SB_W    = 6*CW + DW + 3*PP_W + 3*DP_W + 4;
  localparam int OUT_W   = 4*CW + 2 + FACE_W;
  localparam int OUT_PAD = ((OUT_W + 7) / 8) * 8;

  logic [3*CW-1:0]     center, half;
  logic [3*AB-1:0]     axis_x, axis_y, axis_z;
  logic [TOL_BITS-1:0] tol;

  robb_cfg #(.COORD_BITS(CW), .FRAC_BITS(FRAC_BITS), .AXIS_BITS(AB), .CFG_W(CFG_W)) u_cfg (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .center, .axis_x, .axis_y, .axis_z, .half, .tol
  );

  // whole pipe advances unless a finished result is held
  logic      adv;
  pipe_ctl_t in_ctl, out_ctl;
  logic      out_v;

  assign adv           = !out_v || m_axis_tready;
  assign s_axis_tready = adv;
  assign in_ctl        = '{adv: adv, in_valid: s_axis_tvalid};

  // unpack input transfer
  logic signed [CW-1:0] org_in [3], dir_in [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      org_in[k] = signed'(s_axis_tdata[k*CW +: CW]);
      dir_in[k] = signed'(s_axis_tdata[(3+k)*CW +: CW]);
    end
  end

  logic                    p_valid, p_pmiss;
  logic signed [CW-1:0]    p_org [3], p_dir [3];
  logic [DW-1:0]           p_maxd;
  logic signed [PP_W-1:0]  p_pp [3];
  logic signed [DP_W-1:0]  p_dp [3];
  logic signed [NUM_W-1:0] p_nneg [3], p_npos [3];
  logic [2:0]              p_par;

  robb_proj #(.COORD_BITS(CW), .FRAC_BITS(FRAC_BITS), .AXIS_BITS(AB)) u_proj (
    .clk, .rst, .ctl(in_ctl),
    .org_in, .dir_in, .maxd_in(s_axis_tdata[6*CW +: DW]),
    .center, .axis_x, .axis_y, .axis_z, .half,
    .out_valid(p_valid), .org_out(p_org), .dir_out(p_dir), .maxd_out(p_maxd),
    .pp_out(p_pp), .dp_out(p_dp), .num_neg(p_nneg), .num_pos(p_npos),
    .par(p_par), .pmiss(p_pmiss)
  );

  // six slab dividers
  logic signed [NUM_W:0] t_neg [3], t_pos [3];

  for (genvar a = 0; a < 3; a++) begin : g_div
    robb_div #(.NUM_W(NUM_W), .DEN_W(DP_W)) u_div_neg (
      .clk, .en(adv), .num(p_nneg[a]), .den(p_dp[a]), .quo(t_neg[a])
    );
    robb_div #(.NUM_W(NUM_W), .DEN_W(DP_W)) u_div_pos (
      .clk, .en(adv), .num(p_npos[a]), .den(p_dp[a]), .quo(t_pos[a])
    );
  end

  // side band delay line matching the dividers
  logic [SB_W-1:0] sb_in, sb_out;
  logic [SB_W-1:0] sb [DIV_LAT];
  logic [DIV_LAT-1:0] sb_v;

  assign sb_in = {p_pmiss, p_par,
                  p_dp[2], p_dp[1], p_dp[0], p_pp[2], p_pp[1], p_pp[0], p_maxd,
                  p_dir[2], p_dir[1], p_dir[0], p_org[2], p_org[1], p_org[0]};
  assign sb_out = sb[DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      sb[0] <= sb_in;
      for (int i = 1; i < DIV_LAT; i++) begin
        sb[i] <= sb[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sb_v <= '0;
    end else if (adv) begin
      sb_v <= {sb_v[DIV_LAT-2:0], p_valid};
    end
  end

  logic signed [CW-1:0]   d_org [3], d_dir [3];
  logic signed [PP_W-1:0] d_pp [3];
  logic signed [DP_W-1:0] d_dp [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d_org[k] = signed'(sb_out[k*CW +: CW]);
      d_dir[k] = signed'(sb_out[(3+k)*CW +: CW]);
      d_pp[k]  = signed'(sb_out[6*CW + DW + k*PP_W +: PP_W]);
      d_dp[k]  = signed'(sb_out[6*CW + DW + 3*PP_W + k*DP_W +: DP_W]);
    end
  end

  assign out_ctl = '{adv: adv, in_valid: sb_v[DIV_LAT-1]};

  logic                 r_hit;
  logic [DW-1:0]        r_dist;
  logic signed [CW-1:0] r_pt [3];
  face_t                r_face;

  robb_hit #(.COORD_BITS(CW), .FRAC_BITS(FRAC_BITS), .AXIS_BITS(AB)) u_hit (
    .clk, .rst, .ctl(out_ctl),
    .org(d_org), .dir(d_dir), .maxd(sb_out[6*CW +: DW]), .pp(d_pp), .dp(d_dp),
    .par(sb_out[SB_W-4 +: 3]), .pmiss(sb_out[SB_W-1]),
    .t_neg, .t_pos, .half, .tol,
    .out_valid(out_v), .hit(r_hit), .distance(r_dist), .point(r_pt), .face(r_face)
  );

  // output transfer
  assign m_axis_tvalid = out_v;
  assign m_axis_tuser  = r_hit;
  assign m_axis_tdata  = OUT_PAD'({r_face, r_pt[2], r_pt[1], r_pt[0], r_dist});

  // a miss carries an all-zero payload
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("miss result with nonzero payload");

  // face code stays within the defined faces
  a_face_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[OUT_W-1 -: FACE_W] <= FACE_NEG_Z)
    else $error("face code out of range");

  // a held result stops intake
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output stalled");

  // a face is only reported on a hit
  a_face_hit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[OUT_W-1 -: FACE_W] != FACE_NONE) |-> m_axis_tuser)
    else $error("face without hit");

endmodule
`default_nettype wire
